>>> rtl/pbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbd_pkg
// shared widths, register codes, defaults and the symbol rank lookup
// ----------------------------------------------------------------------------
package pbd_pkg;

    localparam int SYM_W     = 8;
    localparam int PRIO_W    = 5;
    localparam int NUM_REGS  = 7;
    localparam int IDX_W     = 3;
    localparam int ROW_W     = 7;
    localparam int CCOL_W    = 8;
    localparam int BAND_W    = 5;
    localparam int COLUMN_W  = 5;

    localparam int GRID_WIDTH_DEF  = 198;
    localparam int GRID_HEIGHT_DEF = 66;
    localparam int BLOCK_W_DEF     = 7;
    localparam int BLOCK_H_DEF     = 3;

    localparam logic [SYM_W-1:0] BLANK_CODE = 8'h20;

    typedef logic signed [PRIO_W-1:0] prio_t;
    typedef prio_t prio_set_t [NUM_REGS];

    // register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_BLANK      = 3'd0,
        REG_FLOOR      = 3'd1,
        REG_DOOR       = 3'd2,
        REG_WALL       = 3'd3,
        REG_UP_STAIR   = 3'd4,
        REG_DOWN_STAIR = 3'd5,
        REG_PLAYER     = 3'd6
    } reg_idx_t;

    localparam logic [SYM_W-1:0] REG_SYMBOL [NUM_REGS] = '{
        8'h20, 8'h2E, 8'h27, 8'h23, 8'h3C, 8'h3E, 8'h40
    };

    localparam prio_t REG_RESET [NUM_REGS] = '{
        -5'sd15, -5'sd10, -5'sd3, -5'sd5, 5'sd5, 5'sd5, 5'sd10
    };

    // rank of a symbol under the current priorities, 0 when unlisted
    function automatic prio_t rank_of(input logic [SYM_W-1:0] sym, input prio_set_t prios);
        prio_t r;
        r = '0;
        for (int k = 0; k < NUM_REGS; k++)
        begin
            if (REG_SYMBOL[k] == sym)
            begin
                r = prios[k];
            end
        end
        return r;
    endfunction

endpackage

>>> rtl/priority_block_downscale_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_block_downscale_core
// shrinks a raster character grid by blocks, keeping the top priority symbol
// ----------------------------------------------------------------------------
// Takes one grid symbol per cycle in raster order and gives one word per
// completed block (band, column, winning symbol, frame_last on the grid's
// final block). A new symbol is taken every cycle while the output is free
// or draining; a word passes the compare stage and output register after a
// block's last cell. The kept symbol of each block column lives in a
// one-port-write, one-port-read synchronous memory of GRID_WIDTH/BLOCK_W
// entries: it is read when a block's first cell of a row is taken and written
// back at that block's last cell; within a block the running winner is held
// in a register. A write-back that meets a read of the same entry is
// forwarded. The band clear adds no stall: the first row of a band starts
// every block from blank instead of from memory. Cells past the last full
// block column are dropped, and a grid narrower than one block gives no
// words. Priority registers may be written only while the block is idle.
// ----------------------------------------------------------------------------
module priority_block_downscale_core
    import pbd_pkg::*;
#(
    parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = GRID_HEIGHT_DEF,
    parameter int BLOCK_W     = BLOCK_W_DEF,
    parameter int BLOCK_H     = BLOCK_H_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    // config write port
    input  logic                cfg_we,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [PRIO_W-1:0]   cfg_data,
    // symbol input
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [SYM_W-1:0]    symbol,
    // block result output
    output logic                out_valid,
    input  logic                out_stall,
    output logic [BAND_W-1:0]   band,
    output logic [COLUMN_W-1:0] column,
    output logic [SYM_W-1:0]    winner,
    output logic                frame_last
);

    localparam int NUM_COLS  = GRID_WIDTH / BLOCK_W;
    localparam int MEM_DEPTH = (NUM_COLS > 0) ? NUM_COLS : 1;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int COL_W     = (NUM_COLS > 0) ? $clog2(NUM_COLS + 1) : 1;
    localparam int OFF_W     = (BLOCK_W > 1) ? $clog2(BLOCK_W) : 1;
    localparam int ROFF_W    = (BLOCK_H > 1) ? $clog2(BLOCK_H) : 1;

    // priority registers
    prio_set_t prio_reg;

    // raster position of the next input word
    logic [CCOL_W-1:0] ccol_reg;
    logic [OFF_W-1:0]  off_reg;
    logic [COL_W-1:0]  bcol_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [ROFF_W-1:0] roff_reg;
    logic [ROW_W-1:0]  bnd_reg;

    // compare stage
    logic              s1_valid_reg;
    logic [SYM_W-1:0]  s1_sym_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic              s1_first_reg;   // first cell of block in this row
    logic              s1_fresh_reg;   // first row of band, block starts blank
    logic              s1_wb_reg;      // last cell of block in this row
    logic              s1_emit_reg;
    logic              s1_last_reg;
    logic              s1_range_reg;
    logic [ROW_W-1:0]  s1_band_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic [SYM_W-1:0]  rdata_reg;
    logic              fwd_reg;
    logic [SYM_W-1:0]  fwd_data_reg;
    logic [SYM_W-1:0]  acc_reg;

    // output register
    logic                out_valid_reg;
    logic [BAND_W-1:0]   band_reg;
    logic [COLUMN_W-1:0] column_reg;
    logic [SYM_W-1:0]    winner_reg;
    logic                last_reg;

    logic [SYM_W-1:0] mem [MEM_DEPTH];

    logic              s1_go;
    logic              accept;
    logic [SYM_W-1:0]  base;
    logic [SYM_W-1:0]  kept;
    logic              wr_en;
    logic              in_range;
    logic              row_end;
    logic              last_row;
    logic              blk_end;
    logic              band_end;
    logic [ADDR_W-1:0] rd_addr;

    // ------------------------------------------------------------------
    // handshake: compare stage moves on unless its word finds the output
    // register full and stalled
    // ------------------------------------------------------------------
    assign s1_go    = s1_valid_reg && (!s1_emit_reg || !out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_go;
    assign accept   = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // position decode of the incoming word
    // ------------------------------------------------------------------
    assign in_range = bcol_reg < COL_W'(NUM_COLS);
    assign row_end  = ccol_reg == CCOL_W'(GRID_WIDTH - 1);
    assign last_row = row_reg == ROW_W'(GRID_HEIGHT - 1);
    assign blk_end  = off_reg == OFF_W'(BLOCK_W - 1);
    assign band_end = roff_reg == ROFF_W'(BLOCK_H - 1);
    assign rd_addr  = bcol_reg[ADDR_W-1:0];

    // ------------------------------------------------------------------
    // compare: memory (or forward, or blank) at block start, else running
    // winner; later symbol wins only on strictly higher rank
    // ------------------------------------------------------------------
    always_comb
    begin
        if (!s1_first_reg)
        begin
            base = acc_reg;
        end
        else if (s1_fresh_reg)
        begin
            base = BLANK_CODE;
        end
        else if (fwd_reg)
        begin
            base = fwd_data_reg;
        end
        else
        begin
            base = rdata_reg;
        end

        if (rank_of(s1_sym_reg, prio_reg) > rank_of(base, prio_reg))
        begin
            kept = s1_sym_reg;
        end
        else
        begin
            kept = base;
        end
    end

    assign wr_en = s1_go && s1_range_reg && s1_wb_reg;

    // ------------------------------------------------------------------
    // control state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_REGS; k++)
            begin
                prio_reg[k] <= REG_RESET[k];
            end
            ccol_reg      <= '0;
            off_reg       <= '0;
            bcol_reg      <= '0;
            row_reg       <= '0;
            roff_reg      <= '0;
            bnd_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index < IDX_W'(NUM_REGS)))
            begin
                prio_reg[cfg_index] <= prio_t'(cfg_data);
            end

            if (accept)
            begin
                if (row_end)
                begin
                    ccol_reg <= '0;
                    off_reg  <= '0;
                    bcol_reg <= '0;
                    if (last_row)
                    begin
                        row_reg  <= '0;
                        roff_reg <= '0;
                        bnd_reg  <= '0;
                    end
                    else
                    begin
                        row_reg <= row_reg + 1'b1;
                        if (band_end)
                        begin
                            roff_reg <= '0;
                            bnd_reg  <= bnd_reg + 1'b1;
                        end
                        else
                        begin
                            roff_reg <= roff_reg + 1'b1;
                        end
                    end
                end
                else
                begin
                    ccol_reg <= ccol_reg + 1'b1;
                    if (blk_end)
                    begin
                        off_reg <= '0;
                        if (in_range)
                        begin
                            bcol_reg <= bcol_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        off_reg <= off_reg + 1'b1;
                    end
                end
            end

            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_go && s1_emit_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // payload of the compare stage, memory read and forward capture
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sym_reg   <= symbol;
            s1_addr_reg  <= rd_addr;
            s1_first_reg <= off_reg == '0;
            s1_fresh_reg <= roff_reg == '0;
            s1_wb_reg    <= blk_end;
            s1_emit_reg  <= in_range && blk_end && (band_end || last_row);
            s1_last_reg  <= last_row && (bcol_reg == COL_W'(NUM_COLS - 1));
            s1_range_reg <= in_range;
            s1_band_reg  <= bnd_reg;
            s1_col_reg   <= bcol_reg;
            rdata_reg    <= mem[rd_addr];
            // write-back of the same entry at this edge is not in the read yet
            fwd_reg      <= wr_en && (s1_addr_reg == rd_addr);
            fwd_data_reg <= kept;
        end

        if (s1_go)
        begin
            acc_reg <= kept;
        end

        if (wr_en)
        begin
            mem[s1_addr_reg] <= kept;
        end

        if (s1_go && s1_emit_reg)
        begin
            band_reg   <= BAND_W'(s1_band_reg);
            column_reg <= COLUMN_W'(s1_col_reg);
            winner_reg <= kept;
            last_reg   <= s1_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign band       = band_reg;
    assign column     = column_reg;
    assign winner     = winner_reg;
    assign frame_last = last_reg;

endmodule

>>> test/tb_priority_block_downscale_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_priority_block_downscale_core
// self-checking bench for the priority block downscaler
// ----------------------------------------------------------------------------
// Streams character codes into the core in raster order and keeps a running
// model of the block winners on the side. Every accepted symbol updates the
// model, and every block that closes queues the word the core must give. A
// checker pops that queue on each accepted output word and compares the
// fields one by one. The priorities go through the reset values, all lowest,
// all highest, alternating extremes and random sets. A write to an index past
// the register file is included. Both sides idle at random, with one long
// stretch where neither does.
// ----------------------------------------------------------------------------
module tb_priority_block_downscale_core
    import pbd_pkg::*;
();

    localparam int CLK_PERIOD    = 20;
    localparam int GRID_W        = GRID_WIDTH_DEF;
    localparam int GRID_H        = GRID_HEIGHT_DEF;
    localparam int BLK_W         = BLOCK_W_DEF;
    localparam int BLK_H         = BLOCK_H_DEF;
    localparam int BLOCK_COLS    = GRID_W / BLK_W;
    // words pass the core's compare and output registers, so this leaves margin
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int IDLE_PERCENT  = 35;

    // an index past the register file, the core must ignore it
    localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam logic [SYM_W-1:0] SYM_FLOOR  = 8'h2E;
    localparam logic [SYM_W-1:0] SYM_DOOR   = 8'h27;
    localparam logic [SYM_W-1:0] SYM_WALL   = 8'h23;
    localparam logic [SYM_W-1:0] SYM_UP     = 8'h3C;
    localparam logic [SYM_W-1:0] SYM_DOWN   = 8'h3E;
    localparam logic [SYM_W-1:0] SYM_PLAYER = 8'h40;

    localparam prio_t PRIO_MIN = -5'sd16;
    localparam prio_t PRIO_MAX = 5'sd15;

    // one word the core owes us
    typedef struct {
        logic [BAND_W-1:0]   band;
        logic [COLUMN_W-1:0] column;
        logic [SYM_W-1:0]    winner;
        logic                frame_last;
    } block_word_t;

    // ------------------------------------------------------------------
    // dut signals, all inputs known from time zero
    // ------------------------------------------------------------------
    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                cfg_we     = 1'b0;
    logic [IDX_W-1:0]    cfg_index  = '0;
    logic [PRIO_W-1:0]   cfg_data   = '0;
    logic                in_valid   = 1'b0;
    logic                in_stall;
    logic [SYM_W-1:0]    symbol     = '0;
    logic                out_valid;
    logic                out_stall  = 1'b0;
    logic [BAND_W-1:0]   band;
    logic [COLUMN_W-1:0] column;
    logic [SYM_W-1:0]    winner;
    logic                frame_last;

    // ------------------------------------------------------------------
    // model state: priorities, best symbol per block column, scan position
    // ------------------------------------------------------------------
    prio_set_t        prio_now;
    logic [SYM_W-1:0] column_best [BLOCK_COLS];
    int unsigned      scan_col;
    int unsigned      scan_row;
    block_word_t      pending_blocks [$];

    // run bookkeeping
    bit          no_idle;
    int unsigned error_count;
    int unsigned symbols_sent;
    int unsigned words_checked;
    int unsigned reg_writes;

    priority_block_downscale_core #(
        .GRID_WIDTH  (GRID_W),
        .GRID_HEIGHT (GRID_H),
        .BLOCK_W     (BLK_W),
        .BLOCK_H     (BLK_H)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .symbol     (symbol),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .band       (band),
        .column     (column),
        .winner     (winner),
        .frame_last (frame_last)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // mismatch report, one line each
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("mismatch at %0t ns: %s, got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // model
    // ------------------------------------------------------------------
    // unlisted codes rank zero
    function automatic prio_t symbol_rank(input logic [SYM_W-1:0] s);
        case (s)
            BLANK_CODE: return prio_now[REG_BLANK];
            SYM_FLOOR:  return prio_now[REG_FLOOR];
            SYM_DOOR:   return prio_now[REG_DOOR];
            SYM_WALL:   return prio_now[REG_WALL];
            SYM_UP:     return prio_now[REG_UP_STAIR];
            SYM_DOWN:   return prio_now[REG_DOWN_STAIR];
            SYM_PLAYER: return prio_now[REG_PLAYER];
            default:    return '0;
        endcase
    endfunction

    task automatic model_reset();
        prio_now = REG_RESET;
        foreach (column_best[c])
        begin
            column_best[c] = BLANK_CODE;
        end
        scan_col = 0;
        scan_row = 0;
    endtask

    // one accepted symbol: update the block column and queue a word if it closes
    task automatic model_take_symbol(input logic [SYM_W-1:0] s);
        int unsigned bcol;
        block_word_t w;
        bcol = scan_col / BLK_W;
        // first cell of a band starts every column from blank
        if (scan_col == 0 && (scan_row % BLK_H) == 0)
        begin
            foreach (column_best[c])
            begin
                column_best[c] = BLANK_CODE;
            end
        end
        // trailing cells past the last full block are dropped
        if (bcol < BLOCK_COLS)
        begin
            // strictly greater wins, so ties keep the earlier symbol
            if (symbol_rank(column_best[bcol]) < symbol_rank(s))
            begin
                column_best[bcol] = s;
            end
            // block closes on its last column, at a band's last row or the grid's last row
            if ((scan_col % BLK_W) == BLK_W - 1 &&
                ((scan_row % BLK_H) == BLK_H - 1 || scan_row == GRID_H - 1))
            begin
                w.band       = BAND_W'(scan_row / BLK_H);
                w.column     = COLUMN_W'(bcol);
                w.winner     = column_best[bcol];
                w.frame_last = (scan_row == GRID_H - 1) && (bcol == BLOCK_COLS - 1);
                pending_blocks.push_back(w);
            end
        end
        scan_col++;
        if (scan_col >= GRID_W)
        begin
            scan_col = 0;
            scan_row++;
            if (scan_row >= GRID_H)
            begin
                scan_row = 0;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // output side: random stall and the word checker
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        out_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PERCENT);
    end

    always @(posedge clk)
    begin : check_words
        block_word_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_blocks.size() == 0)
            begin
                report_mismatch("word with nothing pending, winner", winner, -1);
            end
            else
            begin
                want = pending_blocks.pop_front();
                words_checked++;
                if (band !== want.band)
                begin
                    report_mismatch("band", band, want.band);
                end
                if (column !== want.column)
                begin
                    report_mismatch("column", column, want.column);
                end
                if (winner !== want.winner)
                begin
                    report_mismatch("winner", winner, want.winner);
                end
                if (frame_last !== want.frame_last)
                begin
                    report_mismatch("frame_last", frame_last, want.frame_last);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    // mostly the seven ranked symbols so blocks have real contests
    function automatic logic [SYM_W-1:0] random_symbol();
        if ($urandom_range(0, 99) < 75)
        begin
            return REG_SYMBOL[$urandom_range(0, NUM_REGS - 1)];
        end
        return SYM_W'($urandom_range(0, 255));
    endfunction

    // called at a rising edge, returns at the edge that took the word
    task automatic send_symbol(input logic [SYM_W-1:0] s);
        if (!no_idle)
        begin
            while ($urandom_range(0, 99) < IDLE_PERCENT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        symbol   <= s;
        @(posedge clk);
        while (in_stall !== 1'b0)
        begin
            @(posedge clk);
        end
        model_take_symbol(s);
        symbols_sent++;
    endtask

    task automatic send_random(input int unsigned count);
        repeat (count)
        begin
            send_symbol(random_symbol());
        end
    endtask

    // stop input, let every owed word out, then give the pipeline time to settle
    task automatic wait_idle();
        int unsigned waited;
        in_valid <= 1'b0;
        waited = 0;
        while (pending_blocks.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_blocks.size() != 0)
        begin
            report_mismatch("words never delivered", 0, pending_blocks.size());
            pending_blocks.delete();
        end
        repeat (SETTLE_CYCLES)
        begin
            @(posedge clk);
        end
    endtask

    // leaves cfg_we high, the caller lowers it after its last write
    task automatic write_register(input logic [IDX_W-1:0] idx, input logic [PRIO_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        if (idx < NUM_REGS)
        begin
            prio_now[idx] = data;
        end
        reg_writes++;
    endtask

    task automatic write_priorities(input prio_set_t vals);
        for (int k = 0; k < NUM_REGS; k++)
        begin
            write_register(IDX_W'(k), vals[k]);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_random_priorities();
        prio_set_t vals;
        foreach (vals[k])
        begin
            vals[k] = prio_t'($urandom_range(0, 31));
        end
        write_priorities(vals);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // field extremes, every ranked symbol and back to back ties at reset ranks
    task automatic test_directed_symbols();
        logic [SYM_W-1:0] codes [20];
        codes = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h55, 8'hAA,
                  BLANK_CODE, SYM_FLOOR, SYM_DOOR, SYM_WALL, SYM_UP, SYM_DOWN, SYM_PLAYER,
                  8'h21, 8'h3D, 8'h01, 8'hFE,
                  SYM_DOWN, SYM_UP, SYM_PLAYER};
        foreach (codes[i])
        begin
            send_symbol(codes[i]);
        end
    endtask

    task automatic test_reset_priorities();
        send_random(200);
    endtask

    task automatic test_extreme_priorities();
        prio_set_t vals;
        wait_idle();
        foreach (vals[k])
        begin
            vals[k] = PRIO_MIN;
        end
        write_priorities(vals);
        send_random(150);
        wait_idle();
        foreach (vals[k])
        begin
            vals[k] = PRIO_MAX;
        end
        write_priorities(vals);
        send_random(150);
        wait_idle();
        foreach (vals[k])
        begin
            vals[k] = (k % 2) ? PRIO_MAX : PRIO_MIN;
        end
        write_priorities(vals);
        send_random(150);
        wait_idle();
        foreach (vals[k])
        begin
            vals[k] = (k % 2) ? PRIO_MIN : PRIO_MAX;
        end
        write_priorities(vals);
        send_random(150);
    endtask

    // nothing may change when the index is past the register file
    task automatic test_unused_index();
        wait_idle();
        write_register(REG_UNUSED, PRIO_W'($urandom_range(0, 31)));
        write_register(REG_UNUSED, PRIO_MAX);
        cfg_we <= 1'b0;
        @(posedge clk);
        send_random(80);
    endtask

    task automatic test_random_priorities();
        repeat (4)
        begin
            wait_idle();
            write_random_priorities();
            send_random(75);
        end
    endtask

    // long stretch with neither side idling
    task automatic test_back_to_back();
        no_idle = 1'b1;
        send_random(300);
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        model_reset();
        no_idle       = 1'b0;
        error_count   = 0;
        symbols_sent  = 0;
        words_checked = 0;
        reg_writes    = 0;

        repeat (5)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_symbols();
        test_reset_priorities();
        test_extreme_priorities();
        test_unused_index();
        test_random_priorities();
        test_back_to_back();
        wait_idle();

        $display("ran %0d symbols into %0d checked block words",
                 symbols_sent, words_checked);
        $display("priorities: reset, all lowest, all highest, alternating, random; %0d writes",
                 reg_writes);
        if (error_count == 0)
        begin
            $display("** priority_block_downscale_core: PASSED **");
        end
        else
        begin
            $display("** priority_block_downscale_core: FAILED **");
        end
        $finish;
    end

    // watchdog, well past the slowest legal run
    initial
    begin
        #15_000_000;
        $display("watchdog expired, %0d words still pending", pending_blocks.size());
        $display("** priority_block_downscale_core: FAILED **");
        $finish;
    end

endmodule

>>> sim.f
rtl/pbd_pkg.sv
rtl/priority_block_downscale_core.sv
test/tb_priority_block_downscale_core.sv
